// ===== sv/dlb_pkg.sv =====
// Shared types, widths and constants for the detection letterbox decoder.
package dlb_pkg;

  localparam int unsigned COORD_FRAC_BITS = 4;

  localparam int unsigned CRD_W   = 16;
  localparam int unsigned PAD_W   = 12;
  localparam int unsigned INV_W   = 24;
  localparam int unsigned SCORE_W = 16;
  localparam int unsigned CLS_W   = 8;
  localparam int unsigned SIZE_W  = 13;
  localparam int unsigned OUT_W   = 16;
  localparam int unsigned ADDR_W  = 5;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned RND_SH  = 16;

  // padded-corner difference, product, and mapped frame coordinate widths
  localparam int unsigned D_W    = ((PAD_W + COORD_FRAC_BITS + 1 > CRD_W) ?
                                    (PAD_W + COORD_FRAC_BITS + 1) : CRD_W) + 1;
  localparam int unsigned PROD_W = D_W + INV_W + 1;
  localparam int unsigned MAP_W  = PROD_W - RND_SH;
  localparam int unsigned SPAN_W = SIZE_W + COORD_FRAC_BITS;

  localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(4096);
  localparam logic [SIZE_W-1:0] SIZE_MIN = SIZE_W'(1);

  localparam logic [CLS_W-1:0] CLS_PERSON = CLS_W'(0);
  localparam logic [CLS_W-1:0] CLS_CAR    = CLS_W'(2);

  typedef enum logic [2:0] {
    REG_PAD_LEFT,
    REG_PAD_TOP,
    REG_INV_SCALE,
    REG_CONF_THR,
    REG_FRAME_W,
    REG_FRAME_H
  } reg_idx_e;

  localparam logic [PAD_W-1:0]   PAD_LEFT_RST  = '0;
  localparam logic [PAD_W-1:0]   PAD_TOP_RST   = '0;
  localparam logic [INV_W-1:0]   INV_SCALE_RST = INV_W'(65536);
  localparam logic [SCORE_W-1:0] CONF_THR_RST  = '0;
  localparam logic [SIZE_W-1:0]  FRAME_W_RST   = SIZE_W'(640);
  localparam logic [SIZE_W-1:0]  FRAME_H_RST   = SIZE_W'(480);

  typedef struct packed {
    logic signed [CRD_W-1:0] corner_a_x;
    logic signed [CRD_W-1:0] corner_a_y;
    logic signed [CRD_W-1:0] corner_b_x;
    logic signed [CRD_W-1:0] corner_b_y;
    logic [SCORE_W-1:0]      score;
    logic [CLS_W-1:0]        class_number;
  } in_beat_t;

  typedef struct packed {
    logic               kind;
    logic [SCORE_W-1:0] kept_score;
    logic [OUT_W-1:0]   box_x;
    logic [OUT_W-1:0]   box_y;
    logic [OUT_W-1:0]   box_w;
    logic [OUT_W-1:0]   box_h;
  } out_beat_t;

  typedef struct packed {
    logic [SPAN_W-1:0] pos;
    logic [SPAN_W-1:0] len;
    logic              ok;
  } axis_t;

  function automatic logic [OUT_W-1:0] sat_out(input logic [31:0] v);
    logic [OUT_W-1:0] r;
    r = (v > 32'(16'hFFFF)) ? 16'hFFFF : v[OUT_W-1:0];
    return r;
  endfunction

endpackage

// ===== sv/dlb_corner_map.sv =====
// Maps one model-input coordinate to frame space: remove padding, scale, round half up.
module dlb_corner_map (
  input  logic signed [dlb_pkg::CRD_W-1:0] coord_i,
  input  logic [dlb_pkg::PAD_W-1:0]        pad_i,
  input  logic [dlb_pkg::INV_W-1:0]        inv_scale_i,
  output logic signed [dlb_pkg::MAP_W-1:0] frame_o
);
  import dlb_pkg::*;

  logic [D_W-1:0]           pad_sh;
  logic signed [D_W-1:0]    diff;
  logic signed [INV_W:0]    inv_s;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] rnd;

  assign pad_sh  = D_W'(pad_i) << COORD_FRAC_BITS;
  assign diff    = D_W'(coord_i) - signed'(pad_sh);
  assign inv_s   = signed'({1'b0, inv_scale_i});
  assign prod    = diff * inv_s;
  assign rnd     = prod + signed'(PROD_W'(1) << (RND_SH - 1));
  assign frame_o = rnd[PROD_W-1:RND_SH];

endmodule

// ===== sv/dlb_axis_clip.sv =====
// Clamps one axis of a box to the frame and checks its minimum size.
module dlb_axis_clip (
  input  logic signed [dlb_pkg::MAP_W-1:0] p1_i,
  input  logic signed [dlb_pkg::MAP_W-1:0] p2_i,
  input  logic [dlb_pkg::SIZE_W-1:0]       size_i,
  output dlb_pkg::axis_t                   axis_o
);
  import dlb_pkg::*;

  localparam logic [SPAN_W-1:0] ONE = SPAN_W'(1) << COORD_FRAC_BITS;

  logic [SIZE_W-1:0]       size_s;
  logic [SPAN_W-1:0]       span;
  logic [SPAN_W-1:0]       hi_lim;
  logic signed [MAP_W-1:0] lo;
  logic signed [MAP_W:0]   delta;
  logic [MAP_W:0]          mag;
  logic [SPAN_W-1:0]       pos;
  logic [SPAN_W-1:0]       room;
  logic [SPAN_W-1:0]       len;

  always_comb begin
    if (size_i == '0) begin
      size_s = SIZE_MIN;
    end else if (size_i > SIZE_MAX) begin
      size_s = SIZE_MAX;
    end else begin
      size_s = size_i;
    end
  end

  assign span   = SPAN_W'(size_s) << COORD_FRAC_BITS;
  assign hi_lim = span - ONE;
  assign lo     = (p1_i < p2_i) ? p1_i : p2_i;
  assign delta  = (MAP_W+1)'(p2_i) - (MAP_W+1)'(p1_i);
  assign mag    = delta[MAP_W] ? (MAP_W+1)'(-delta) : (MAP_W+1)'(delta);

  always_comb begin
    if (lo < 0) begin
      pos = '0;
    end else if (lo > signed'(MAP_W'(hi_lim))) begin
      pos = hi_lim;
    end else begin
      pos = lo[SPAN_W-1:0];
    end
  end

  assign room = span - pos;
  assign len  = (mag > (MAP_W+1)'(room)) ? room : mag[SPAN_W-1:0];

  assign axis_o.pos = pos;
  assign axis_o.len = len;
  assign axis_o.ok  = len > ONE;

endmodule

// ===== sv/detection_letterbox_decode.sv =====
// Top level of the detection letterbox decoder: config registers and three-stage pipeline.
// Takes one detector row per cycle while the pipeline advances and returns a kept box
// from stage three after stages one and two, or nothing if the row is dropped. Stage
// one holds the row and checks score and class, stage two holds the four corners
// mapped through four parallel signed multipliers, stage three holds the clamped
// result. The whole pipeline advances together whenever the output register is empty
// or taken, so with out_ready_i high the block sustains one row per clock. Registers
// must be written over the APB port only while no row is in flight; no check enforces it.
module detection_letterbox_decode (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dlb_pkg::ADDR_W-1:0]  paddr,
  input  logic [dlb_pkg::DATA_W-1:0]  pwdata,
  output logic [dlb_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  dlb_pkg::in_beat_t           in_beat_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output dlb_pkg::out_beat_t          out_beat_o
);
  import dlb_pkg::*;

  localparam logic [OUT_W-1:0] ONE_OUT = OUT_W'(1) << COORD_FRAC_BITS;

  logic [PAD_W-1:0]   pad_left_q, pad_top_q;
  logic [INV_W-1:0]   inv_scale_q;
  logic [SCORE_W-1:0] conf_thr_q;
  logic [SIZE_W-1:0]  frame_w_q, frame_h_q;

  reg_idx_e reg_idx;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pad_left_q  <= PAD_LEFT_RST;
      pad_top_q   <= PAD_TOP_RST;
      inv_scale_q <= INV_SCALE_RST;
      conf_thr_q  <= CONF_THR_RST;
      frame_w_q   <= FRAME_W_RST;
      frame_h_q   <= FRAME_H_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_PAD_LEFT:  pad_left_q  <= pwdata[PAD_W-1:0];
        REG_PAD_TOP:   pad_top_q   <= pwdata[PAD_W-1:0];
        REG_INV_SCALE: inv_scale_q <= pwdata[INV_W-1:0];
        REG_CONF_THR:  conf_thr_q  <= pwdata[SCORE_W-1:0];
        REG_FRAME_W:   frame_w_q   <= pwdata[SIZE_W-1:0];
        REG_FRAME_H:   frame_h_q   <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PAD_LEFT:  prdata = DATA_W'(pad_left_q);
      REG_PAD_TOP:   prdata = DATA_W'(pad_top_q);
      REG_INV_SCALE: prdata = DATA_W'(inv_scale_q);
      REG_CONF_THR:  prdata = DATA_W'(conf_thr_q);
      REG_FRAME_W:   prdata = DATA_W'(frame_w_q);
      REG_FRAME_H:   prdata = DATA_W'(frame_h_q);
      default:       prdata = '0;
    endcase
  end

  // pipeline
  logic adv;
  logic s1_valid_q;
  in_beat_t s1_q;
  logic s2_valid_q;
  logic signed [MAP_W-1:0] x1_q, y1_q, x2_q, y2_q;
  logic [SCORE_W-1:0] s2_score_q;
  logic s2_kind_q;
  logic out_valid_q;
  out_beat_t out_q;

  logic signed [MAP_W-1:0] x1_d, y1_d, x2_d, y2_d;
  logic keep1;
  axis_t ax_x, ax_y;
  out_beat_t out_d;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  assign keep1 = (s1_q.score >= conf_thr_q) &&
                 ((s1_q.class_number == CLS_PERSON) || (s1_q.class_number == CLS_CAR));

  dlb_corner_map u_map_x1 (
    .coord_i(s1_q.corner_a_x), .pad_i(pad_left_q), .inv_scale_i(inv_scale_q), .frame_o(x1_d)
  );
  dlb_corner_map u_map_y1 (
    .coord_i(s1_q.corner_a_y), .pad_i(pad_top_q), .inv_scale_i(inv_scale_q), .frame_o(y1_d)
  );
  dlb_corner_map u_map_x2 (
    .coord_i(s1_q.corner_b_x), .pad_i(pad_left_q), .inv_scale_i(inv_scale_q), .frame_o(x2_d)
  );
  dlb_corner_map u_map_y2 (
    .coord_i(s1_q.corner_b_y), .pad_i(pad_top_q), .inv_scale_i(inv_scale_q), .frame_o(y2_d)
  );

  dlb_axis_clip u_clip_x (.p1_i(x1_q), .p2_i(x2_q), .size_i(frame_w_q), .axis_o(ax_x));
  dlb_axis_clip u_clip_y (.p1_i(y1_q), .p2_i(y2_q), .size_i(frame_h_q), .axis_o(ax_y));

  assign out_d.kind       = s2_kind_q;
  assign out_d.kept_score = s2_score_q;
  assign out_d.box_x      = sat_out(32'(ax_x.pos));
  assign out_d.box_y      = sat_out(32'(ax_y.pos));
  assign out_d.box_w      = sat_out(32'(ax_x.len));
  assign out_d.box_h      = sat_out(32'(ax_y.len));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= in_valid_i;
      s2_valid_q  <= s1_valid_q && keep1;
      out_valid_q <= s2_valid_q && ax_x.ok && ax_y.ok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q       <= in_beat_i;
      x1_q       <= x1_d;
      y1_q       <= y1_d;
      x2_q       <= x2_d;
      y2_q       <= y2_d;
      s2_score_q <= s1_q.score;
      s2_kind_q  <= (s1_q.class_number == CLS_CAR);
      out_q      <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

  a_min_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.box_w > ONE_OUT)
    else $error("kept box not wider than one pixel");

  a_min_height: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.box_h > ONE_OUT)
    else $error("kept box not taller than one pixel");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !adv) |=> (s1_valid_q && $stable(s1_q)))
    else $error("stage one row lost during stall");

  a_s2_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && !adv) |=> (s2_valid_q && $stable(x1_q) && $stable(y2_q)))
    else $error("stage two row lost during stall");

endmodule
